@@ hw/rtl/swrm_pkg.sv @@
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared codes and register defaults of the sliding window rate meter.
// ----------------------------------------------------------------------------
package swrm_pkg;

  localparam logic [1:0] FN_ADD   = 2'd0;
  localparam logic [1:0] FN_QUERY = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  localparam logic [1:0] REG_WINDOW_MS    = 2'd0;
  localparam logic [1:0] REG_WINDOW_SLOTS = 2'd1;
  localparam logic [1:0] REG_SCALE_Q16    = 2'd2;

  localparam logic [19:0] RESET_WINDOW_MS    = 20'd1000;
  localparam logic [7:0]  RESET_WINDOW_SLOTS = 8'd100;
  localparam logic [31:0] RESET_SCALE_Q16    = 32'd524288000;

  localparam logic [23:0] SAMPLES_MAX = 24'hFFFFFF;

endpackage

@@ hw/rtl/swrm_if.sv @@
// ----------------------------------------------------------------------------
// swrm interfaces
// Sample, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swrm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] byte_count;
  logic [47:0] time_ms;
  modport source (output valid, func, byte_count, time_ms, input ready);
  modport sink (input valid, func, byte_count, time_ms, output ready);
endinterface

interface swrm_out_if;
  logic        valid;
  logic        ready;
  logic        rate_valid;
  logic [62:0] rate;
  modport source (output valid, rate_valid, rate, input ready);
  modport sink (input valid, rate_valid, rate, output ready);
endinterface

interface swrm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/sliding_window_rate_meter.sv @@
// ----------------------------------------------------------------------------
// sliding_window_rate_meter
// Byte rate over a sliding window of ring slots, one shared shift-subtract
// divider and one 32x32 multiplier under a sequencer.
// ----------------------------------------------------------------------------
// channel  dir  payload                      role
// samp     in   func, byte_count, time_ms    add / query / clear items
// result   out  rate_valid, rate             one item per query
// cfg      in   index, data                  register writes
//
// Add: slide if due (divide, then read and update per expired slot), then
// ADD_RD, ADD_UPD. Query: same slide, then Q_MUL0, Q_MUL1 and a divide.
// Geometry write: two divides. Clear and scale write: done in IDLE.
// rst clears all state at once (per-slot valid bits). One item at a time;
// result holds until taken.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter
  import swrm_pkg::*;
#(
  parameter int MAX_SLOTS = 128
) (
  input  logic        clk,
  input  logic        rst,
  swrm_in_if.sink     samp,
  swrm_out_if.source  result,
  swrm_cfg_if.sink    cfg
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int RST_N = (100 > MAX_SLOTS) ? MAX_SLOTS : 100;
  localparam int RST_SLOT = (1000 + RST_N - 1) / RST_N;
  localparam int RST_USED = (1000 + RST_SLOT - 1) / RST_SLOT;

  typedef enum logic [4:0] {
    IDLE, GEO1, GEO_DIV1, GEO2, GEO_DIV2, GEO_FIN,
    SLIDE_CHK, SLIDE_DIV, SLIDE_STEPS, WALK_RD, WALK_UPD,
    ADD_RD, ADD_UPD, Q_EVAL, Q_CHK, Q_MUL0, Q_MUL1, Q_SUM, Q_DIV, Q_FIN, OUT
  } state_t;

  state_t state;

  logic [19:0] window_ms;
  logic [7:0]  window_slots;
  logic [31:0] scale_q16;
  logic [19:0] slot_ms;
  logic [CNT_W-1:0] slots_used;

  logic [MAX_SLOTS-1:0] vld;
  logic [47:0] window_bytes;
  logic [31:0] window_samples;
  logic [IDX_W-1:0] newest_slot;
  logic [47:0] newest_start_ms;
  logic [47:0] first_sample_ms;
  logic first_seen;
  logic [47:0] last_sample_ms;
  logic last_seen;

  logic [1:0]  func_r;
  logic [15:0] bc_r;
  logic [47:0] now_r;
  logic recent_r;
  logic [CNT_W-1:0] walk_cnt;
  logic [19:0] period;
  logic [63:0] prod_lo;
  logic [63:0] prod_hi;
  logic out_rv;
  logic [62:0] out_rate;

  logic [127:0] num;
  logic [64:0]  rem;
  logic [63:0]  den;
  logic [7:0]   dcnt;

  logic [63:0] mem [MAX_SLOTS];
  logic [63:0] rd_data;
  logic rd_vld;
  logic [IDX_W-1:0] rd_addr;
  logic mem_we;
  logic [63:0] mem_wd;

  logic [19:0] w_eff;
  logic [7:0]  n_eff;
  logic [64:0] rem_sh;
  logic div_ge;
  logic div_run;
  logic [IDX_W-1:0] slot_nxt;
  logic [39:0] ent_bytes;
  logic [23:0] ent_samples;
  logic [48:0] elapsed;
  logic [49:0] drop_sum;
  logic drop;
  logic short_step;
  logic [20:0] w15;
  logic [49:0] recent_thr;
  logic recent_in;
  logic [49:0] pd;
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  logic [20:0] geo_num1;
  logic [20:0] geo_num2;
  state_t post_state;

  assign w_eff = (window_ms == 20'd0) ? 20'd1 : window_ms;
  assign n_eff = (window_slots == 8'd0) ? 8'd1 :
                 (32'(window_slots) > MAX_SLOTS) ? 8'(MAX_SLOTS) : window_slots;
  assign geo_num1 = {1'b0, w_eff} + {13'b0, n_eff} - 21'd1;
  assign geo_num2 = {1'b0, w_eff} + {1'b0, num[19:0]} - 21'd1;

  assign rem_sh = {rem[63:0], num[127]};
  assign div_ge = rem_sh >= {1'b0, den};
  assign div_run = (state == GEO_DIV1) || (state == GEO_DIV2) ||
                   (state == SLIDE_DIV) || (state == Q_DIV);

  assign slot_nxt = ({1'b0, newest_slot} + CNT_W'(1) >= slots_used) ?
                    '0 : newest_slot + IDX_W'(1);
  assign rd_addr = (state == WALK_RD) ? slot_nxt : newest_slot;
  assign ent_bytes = rd_vld ? rd_data[63:24] : 40'd0;
  assign ent_samples = rd_vld ? rd_data[23:0] : 24'd0;

  assign elapsed = {1'b0, now_r} - {1'b0, newest_start_ms};
  assign drop_sum = {elapsed[48], elapsed} + {30'b0, w_eff};
  assign drop = drop_sum[49] || (drop_sum == 50'd0);
  assign short_step = elapsed[48] || (elapsed[47:0] < {28'b0, slot_ms});
  assign post_state = (func_r == FN_ADD) ? ADD_RD : Q_EVAL;

  assign w15 = {1'b0, w_eff} + {2'b0, w_eff[19:1]};
  assign recent_thr = {2'b0, samp.time_ms} - {29'b0, w15};
  assign recent_in = (window_samples != 32'd0) && last_seen &&
                     ($signed({2'b0, last_sample_ms}) > $signed(recent_thr));

  assign pd = {2'b0, now_r} - {2'b0, first_sample_ms} + 50'd1;

  assign mul_a = (state == Q_MUL0) ? window_bytes[31:0] : {16'b0, window_bytes[47:32]};
  assign mul_p = mul_a * scale_q16;

  assign mem_we = (state == ADD_UPD) && (ent_samples != SAMPLES_MAX);
  assign mem_wd = {ent_bytes + {24'b0, bc_r}, ent_samples + 24'd1};

  assign cfg.ready = (state == IDLE);
  assign samp.ready = (state == IDLE) && !cfg.valid;
  assign result.valid = (state == OUT);
  assign result.rate_valid = out_rv;
  assign result.rate = out_rate;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[newest_slot] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
    rd_vld <= vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      window_ms <= RESET_WINDOW_MS;
      window_slots <= RESET_WINDOW_SLOTS;
      scale_q16 <= RESET_SCALE_Q16;
      slot_ms <= 20'(RST_SLOT);
      slots_used <= CNT_W'(RST_USED);
      vld <= '0;
      window_bytes <= '0;
      window_samples <= '0;
      newest_slot <= '0;
      newest_start_ms <= '0;
      first_sample_ms <= '0;
      first_seen <= 1'b0;
      last_sample_ms <= '0;
      last_seen <= 1'b0;
      dcnt <= '0;
    end else begin
      if (div_run) begin
        num <= {num[126:0], div_ge};
        rem <= div_ge ? rem_sh - {1'b0, den} : rem_sh;
        dcnt <= dcnt - 8'd1;
      end
      case (state)
        IDLE: begin
          if (cfg.valid) begin
            case (cfg.index)
              REG_WINDOW_MS: begin
                window_ms <= cfg.data[19:0];
                state <= GEO1;
              end
              REG_WINDOW_SLOTS: begin
                window_slots <= cfg.data[7:0];
                state <= GEO1;
              end
              REG_SCALE_Q16: scale_q16 <= cfg.data;
              default: ;
            endcase
          end else if (samp.valid) begin
            func_r <= samp.func;
            bc_r <= samp.byte_count;
            now_r <= samp.time_ms;
            recent_r <= recent_in;
            case (samp.func)
              FN_ADD, FN_QUERY: state <= SLIDE_CHK;
              FN_CLEAR: begin
                vld <= '0;
                window_bytes <= '0;
                window_samples <= '0;
                newest_slot <= '0;
                newest_start_ms <= '0;
                first_sample_ms <= '0;
                first_seen <= 1'b0;
                last_sample_ms <= '0;
                last_seen <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        GEO1: begin
          num <= {geo_num1, 107'b0};
          rem <= '0;
          den <= {56'b0, n_eff};
          dcnt <= 8'd21;
          state <= GEO_DIV1;
        end
        GEO_DIV1: begin
          if (dcnt == 8'd1) state <= GEO2;
        end
        GEO2: begin
          slot_ms <= num[19:0];
          num <= {geo_num2, 107'b0};
          rem <= '0;
          den <= {44'b0, num[19:0]};
          dcnt <= 8'd21;
          state <= GEO_DIV2;
        end
        GEO_DIV2: begin
          if (dcnt == 8'd1) state <= GEO_FIN;
        end
        GEO_FIN: begin
          slots_used <= num[CNT_W-1:0];
          vld <= '0;
          window_bytes <= '0;
          window_samples <= '0;
          newest_slot <= '0;
          newest_start_ms <= '0;
          first_sample_ms <= '0;
          first_seen <= 1'b0;
          last_sample_ms <= '0;
          last_seen <= 1'b0;
          state <= IDLE;
        end
        SLIDE_CHK: begin
          if (drop) begin
            state <= (func_r == FN_ADD) ? IDLE : Q_EVAL;
          end else if (short_step) begin
            state <= post_state;
          end else begin
            num <= {elapsed[47:0], 80'b0};
            rem <= '0;
            den <= {44'b0, slot_ms};
            dcnt <= 8'd48;
            state <= SLIDE_DIV;
          end
        end
        SLIDE_DIV: begin
          if (dcnt == 8'd1) state <= SLIDE_STEPS;
        end
        SLIDE_STEPS: begin
          if (num[47:0] >= {{(48-CNT_W){1'b0}}, slots_used}) begin
            vld <= '0;
            window_bytes <= '0;
            window_samples <= '0;
            newest_slot <= '0;
            newest_start_ms <= now_r;
            state <= post_state;
          end else begin
            walk_cnt <= num[CNT_W-1:0];
            state <= WALK_RD;
          end
        end
        WALK_RD: begin
          newest_slot <= slot_nxt;
          state <= WALK_UPD;
        end
        WALK_UPD: begin
          window_bytes <= window_bytes - {8'b0, ent_bytes};
          window_samples <= window_samples - {8'b0, ent_samples};
          vld[newest_slot] <= 1'b0;
          newest_start_ms <= newest_start_ms + {28'b0, slot_ms};
          walk_cnt <= walk_cnt - CNT_W'(1);
          state <= (walk_cnt == CNT_W'(1)) ? post_state : WALK_RD;
        end
        ADD_RD: state <= ADD_UPD;
        ADD_UPD: begin
          if (ent_samples != SAMPLES_MAX) begin
            if (!first_seen || (window_samples == 32'd0 && !recent_r)) begin
              first_sample_ms <= now_r;
              first_seen <= 1'b1;
            end
            vld[newest_slot] <= 1'b1;
            window_bytes <= window_bytes + {32'b0, bc_r};
            window_samples <= window_samples + 32'd1;
            last_sample_ms <= now_r;
            last_seen <= 1'b1;
          end
          state <= IDLE;
        end
        Q_EVAL: begin
          if (pd[49] || pd == 50'd0) begin
            period <= 20'd1;
          end else if (pd > {30'b0, w_eff}) begin
            period <= w_eff;
          end else begin
            period <= pd[19:0];
          end
          if (!first_seen || window_samples == 32'd0) begin
            out_rv <= 1'b0;
            out_rate <= '0;
            state <= OUT;
          end else begin
            state <= Q_CHK;
          end
        end
        Q_CHK: begin
          if (period <= 20'd1 || (window_samples <= 32'd1 && period < w_eff)) begin
            out_rv <= 1'b0;
            out_rate <= '0;
            state <= OUT;
          end else begin
            state <= Q_MUL0;
          end
        end
        Q_MUL0: begin
          prod_lo <= mul_p;
          state <= Q_MUL1;
        end
        Q_MUL1: begin
          prod_hi <= mul_p;
          state <= Q_SUM;
        end
        Q_SUM: begin
          num <= {64'b0, prod_lo} + {32'b0, prod_hi, 32'b0} + {93'b0, period, 15'b0};
          rem <= '0;
          den <= {28'b0, period, 16'b0};
          dcnt <= 8'd128;
          state <= Q_DIV;
        end
        Q_DIV: begin
          if (dcnt == 8'd1) state <= Q_FIN;
        end
        Q_FIN: begin
          out_rv <= (num[127:63] == 65'd0);
          out_rate <= (num[127:63] == 65'd0) ? num[62:0] : 63'd0;
          state <= OUT;
        end
        OUT: begin
          if (result.ready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_slot_in_ring: assert property (@(posedge clk) disable iff (rst)
    {1'b0, newest_slot} < slots_used)
    else $error("newest slot outside ring");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> !samp.ready && !cfg.ready)
    else $error("ready while busy");

  a_empty_window: assert property (@(posedge clk) disable iff (rst)
    (window_samples == 32'd0) |-> (window_bytes == 48'd0))
    else $error("bytes left in empty window");

  a_no_rate_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.rate_valid |-> result.rate == 63'd0)
    else $error("rate without rate_valid");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == Q_DIV) && (dcnt == 8'd1) |=> (state == Q_FIN))
    else $error("divider sequencing");

endmodule

@@ dv/swrm_checker.sv @@
// ----------------------------------------------------------------------------
// swrm_checker
// Watches the sample, result and configuration channels of the rate meter.
// It keeps its own model of the slot ring, predicts each query's result and
// compares every returned item with the oldest prediction.
// ----------------------------------------------------------------------------
module swrm_checker
  import swrm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  swrm_in_if   samp,
  swrm_out_if  result,
  swrm_cfg_if  cfg,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic        rate_valid;
    logic [62:0] rate;
  } rate_item_t;

  rate_item_t rate_q[$];

  logic [19:0] win_ms;
  logic [7:0]  win_slots;
  logic [31:0] scale;
  logic [39:0] slot_bytes [128];
  logic [23:0] slot_cnt [128];
  logic [47:0] win_bytes;
  logic [31:0] win_cnt;
  int          head;
  longint      head_start, first_ms, last_ms;
  bit          first_ok, last_ok;
  longint      slot_len, slots_used;

  function automatic longint eff_win();
    return (win_ms == 0) ? 1 : longint'(win_ms);
  endfunction

  function automatic void empty_ring();
    for (int i = 0; i < 128; i++) begin
      slot_bytes[i] = '0;
      slot_cnt[i] = '0;
    end
    win_bytes = '0;
    win_cnt = '0;
  endfunction

  function automatic void wipe();
    empty_ring();
    head = 0;
    head_start = 0;
    first_ms = 0;
    first_ok = 0;
    last_ms = 0;
    last_ok = 0;
  endfunction

  function automatic void regeom();
    longint w, n;
    w = eff_win();
    n = (win_slots == 0) ? 1 : longint'(win_slots);
    if (n > 128) n = 128;
    slot_len = (w + n - 1) / n;
    slots_used = (w + slot_len - 1) / slot_len;
  endfunction

  function automatic bit advance(longint now);
    longint el, steps;
    el = now - head_start;
    if (el <= -eff_win()) return 0;
    if (el < slot_len) return 1;
    steps = el / slot_len;
    if (steps >= slots_used) begin
      empty_ring();
      head = 0;
      head_start = now;
      return 1;
    end
    for (longint i = 0; i < steps; i++) begin
      head++;
      if (head >= slots_used || head >= 128) head = 0;
      win_bytes -= 48'(slot_bytes[head]);
      win_cnt -= 32'(slot_cnt[head]);
      slot_bytes[head] = '0;
      slot_cnt[head] = '0;
    end
    head_start += steps * slot_len;
    return 1;
  endfunction

  function automatic void add_bytes(longint bytes, longint now);
    longint w;
    bit recent;
    w = eff_win();
    recent = (win_cnt != 0) && last_ok && (last_ms > now - (w + w / 2));
    if (!advance(now)) return;
    if (slot_cnt[head] >= SAMPLES_MAX) return;
    if (!first_ok || (win_cnt == 0 && !recent)) begin
      first_ms = now;
      first_ok = 1;
    end
    slot_bytes[head] += 40'(bytes);
    slot_cnt[head]++;
    win_bytes += 48'(bytes);
    win_cnt++;
    last_ms = now;
    last_ok = 1;
  endfunction

  function automatic rate_item_t measure(longint now);
    rate_item_t r;
    longint w, p;
    logic [127:0] num, den, q;
    r = '0;
    w = eff_win();
    void'(advance(now));
    if (!first_ok || win_cnt == 0) return r;
    p = now - first_ms + 1;
    if (p < 1) p = 1;
    if (p > w) p = w;
    if (p <= 1 || (win_cnt <= 1 && p < w)) return r;
    num = 128'(win_bytes) * 128'(scale) + 128'(p) * 128'd32768;
    den = 128'(p) * 128'd65536;
    q = num / den;
    if (q >= (128'd1 << 63)) return r;
    r.rate_valid = 1;
    r.rate = q[62:0];
    return r;
  endfunction

  always @(posedge clk) begin
    rate_item_t exp_r;
    if (rst) begin
      win_ms = RESET_WINDOW_MS;
      win_slots = RESET_WINDOW_SLOTS;
      scale = RESET_SCALE_Q16;
      regeom();
      wipe();
      rate_q.delete();
      errors <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_WINDOW_MS: begin
            win_ms = cfg.data[19:0];
            regeom();
            wipe();
          end
          REG_WINDOW_SLOTS: begin
            win_slots = cfg.data[7:0];
            regeom();
            wipe();
          end
          REG_SCALE_Q16: scale = cfg.data;
          default: ;
        endcase
      end
      if (samp.valid && samp.ready) begin
        case (samp.func)
          FN_ADD: add_bytes(longint'(samp.byte_count), longint'(samp.time_ms));
          FN_QUERY: rate_q.push_back(measure(longint'(samp.time_ms)));
          FN_CLEAR: wipe();
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (rate_q.size() == 0) begin
          $display("%0t: unexpected result rate_valid=%0b rate=%0d",
                   $time, result.rate_valid, result.rate);
          errors <= errors + 1;
        end else begin
          exp_r = rate_q.pop_front();
          if (result.rate_valid !== exp_r.rate_valid || result.rate !== exp_r.rate) begin
            $display("%0t: mismatch expected rate_valid=%0b rate=%0d, got rate_valid=%0b rate=%0d",
                     $time, exp_r.rate_valid, exp_r.rate, result.rate_valid, result.rate);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= rate_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the rate meter with directed and random add, query and clear items
// across several window settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import swrm_pkg::*;

  localparam logic [1:0] FN_NONE = 2'd3;
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int QUIET_LIMIT = 30000;
  localparam int SETTLE = 400;

  logic clk = 0;
  logic rst = 1;
  int   errors, pending;
  int   quiet = 0;
  int   cycles = 0;
  longint tnow;

  swrm_in_if  samp_if ();
  swrm_out_if res_if ();
  swrm_cfg_if cfg_if ();

  sliding_window_rate_meter dut (
    .clk(clk), .rst(rst), .samp(samp_if), .result(res_if), .cfg(cfg_if)
  );

  swrm_checker chk (
    .clk(clk), .rst(rst), .samp(samp_if), .result(res_if), .cfg(cfg_if),
    .errors(errors), .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    samp_if.valid = 0;
    samp_if.func = FN_ADD;
    samp_if.byte_count = '0;
    samp_if.time_ms = '0;
    cfg_if.valid = 0;
    cfg_if.index = REG_WINDOW_MS;
    cfg_if.data = '0;
    res_if.ready = 0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  // receiver: random stalls, one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      if (cycles == 6000) begin
        res_if.ready <= 0;
        repeat (3000) @(posedge clk);
      end else begin
        res_if.ready <= (pick_gap() == 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((samp_if.valid && samp_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (res_if.valid && res_if.ready) || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(logic [1:0] fn, logic [15:0] nb, logic [47:0] t, int gap);
    if (gap > 0) begin
      samp_if.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    samp_if.valid <= 1;
    samp_if.func <= fn;
    samp_if.byte_count <= nb;
    samp_if.time_ms <= t;
    @(posedge clk);
    while (!samp_if.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 0;
  endtask

  task automatic drain();
    samp_if.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(int n, longint w, longint slots);
    longint sl, step;
    int r;
    logic [1:0] fn;
    if (w < 1) w = 1;
    if (slots < 1) slots = 1;
    if (slots > 128) slots = 128;
    sl = (w + slots - 1) / slots;
    tnow = $urandom_range(0, 100000);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) step = $urandom_range(0, 32'(2 * sl));
      else if (r < 80) step = $urandom_range(0, 32'(w));
      else if (r < 90) step = w + $urandom_range(0, 32'(2 * w));
      else if (r < 97) step = -longint'($urandom_range(0, 32'(2 * w)));
      else step = {$urandom(), $urandom()};
      tnow = (r >= 97) ? (step & 48'hFFFFFFFFFFFF) : ((tnow + step) & 48'hFFFFFFFFFFFF);
      r = $urandom_range(0, 99);
      if (r < 58) fn = FN_ADD;
      else if (r < 93) fn = FN_QUERY;
      else if (r < 97) fn = FN_CLEAR;
      else fn = FN_NONE;
      send(fn, 16'($urandom()), 48'(tnow), pick_gap());
    end
    drain();
  endtask

  initial begin
    logic [19:0] w;
    logic [7:0]  s;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed, reset geometry 1000 ms / 100 slots
    send(FN_QUERY, 16'd0, 48'd0, 0);
    send(FN_ADD, 16'd100, 48'd1000, 0);
    send(FN_QUERY, 16'd0, 48'd1000, 0);
    send(FN_QUERY, 16'd0, 48'd1500, 1);
    send(FN_ADD, 16'hFFFF, 48'd1600, 0);
    send(FN_QUERY, 16'd0, 48'd1800, 0);
    send(FN_ADD, 16'd0, 48'd1700, 0);
    send(FN_ADD, 16'd7, 48'd0, 0);
    send(FN_QUERY, 16'd0, 48'd100, 0);
    send(FN_QUERY, 16'd0, 48'd3000, 0);
    send(FN_NONE, 16'hFFFF, 48'hFFFFFFFFFFFF, 0);
    send(FN_ADD, 16'd500, 48'd5000, 0);
    send(FN_ADD, 16'd500, 48'd5500, 0);
    send(FN_QUERY, 16'd0, 48'd5999, 0);
    send(FN_ADD, 16'd300, 48'd6900, 0);
    send(FN_QUERY, 16'd0, 48'd7000, 0);
    send(FN_CLEAR, 16'd0, 48'd0, 0);
    send(FN_QUERY, 16'd0, 48'd7000, 0);
    send(FN_ADD, 16'hFFFF, 48'hFFFFFFFFFF00, 0);
    send(FN_ADD, 16'hFFFF, 48'hFFFFFFFFFFFE, 0);
    send(FN_QUERY, 16'd0, 48'hFFFFFFFFFFFF, 0);
    drain();

    write_reg(REG_SCALE_Q16, 32'hFFFFFFFF);
    write_reg(REG_WINDOW_MS, 32'd1);
    write_reg(REG_WINDOW_SLOTS, 32'd1);
    write_reg(REG_NONE, 32'hFFFFFFFF);
    random_phase(100, 1, 1);

    write_reg(REG_WINDOW_MS, 32'hFFFFF);
    write_reg(REG_WINDOW_SLOTS, 32'd128);
    write_reg(REG_SCALE_Q16, 32'd0);
    random_phase(60, 64'hFFFFF, 128);

    write_reg(REG_WINDOW_MS, 32'd0);
    write_reg(REG_WINDOW_SLOTS, 32'd0);
    write_reg(REG_SCALE_Q16, 32'hFFFFFFFF);
    random_phase(60, 1, 1);

    write_reg(REG_WINDOW_MS, 32'd300);
    write_reg(REG_WINDOW_SLOTS, 32'd255);
    write_reg(REG_SCALE_Q16, 32'd65536);
    random_phase(120, 300, 255);

    write_reg(REG_WINDOW_MS, 32'(RESET_WINDOW_MS));
    write_reg(REG_WINDOW_SLOTS, 32'(RESET_WINDOW_SLOTS));
    write_reg(REG_SCALE_Q16, RESET_SCALE_Q16);
    random_phase(120, 1000, 100);

    for (int ph = 0; ph < 4; ph++) begin
      w = 20'($urandom_range(1, 5000));
      s = 8'($urandom_range(1, 140));
      write_reg(REG_WINDOW_MS, 32'(w));
      write_reg(REG_WINDOW_SLOTS, 32'(s));
      write_reg(REG_SCALE_Q16, $urandom());
      random_phase(90, longint'(w), longint'(s));
    end

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/swrm_pkg.sv
hw/rtl/swrm_if.sv
hw/rtl/sliding_window_rate_meter.sv
dv/swrm_checker.sv
dv/tb_top.sv
